/* rtl/core/rmvmm_pkg.sv */
// shared definitions for the running mean / variance / min / max block
// no dependencies
`timescale 1ns / 1ps

package rmvmm_pkg;

    localparam int COUNT_BITS_DEF  = 32;
    localparam int SAMPLE_BITS_DEF = 32;
    localparam int GUARD_BITS      = 16;
    localparam int DIV_W           = 64;
    localparam int DIV_CNT_W       = 7;

    // result returned by the serial divider
    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } div_res_t;

endpackage

/* rtl/core/running_mean_variance_min_max.sv */
// running mean, variance, minimum and maximum of a sample stream
// the first sample is loaded directly; later samples go through a mean divide, a
//   shift-add multiply, an accumulate, a variance divide, a divide by the count and
//   a bit-serial square root, the three divides on one shared serial divider
// one item in flight; the next item is taken while a result waits on the m_ side
// synchronous active-low reset clears the statistics and the handshake state
`timescale 1ns / 1ps

module running_mean_variance_min_max #(
    parameter int COUNT_BITS  = rmvmm_pkg::COUNT_BITS_DEF,
    parameter int SAMPLE_BITS = rmvmm_pkg::SAMPLE_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_sample,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_count,
    output logic signed [31:0] m_mean_out,
    output logic [63:0]        m_sq_dev_sum,
    output logic signed [31:0] m_minimum,
    output logic signed [31:0] m_maximum,
    output logic [63:0]        m_variance,
    output logic [31:0]        m_std_error,
    output logic               m_variance_valid,
    output logic               m_overflow
);

    localparam int G      = rmvmm_pkg::GUARD_BITS;
    localparam int MEAN_W = SAMPLE_BITS + G;
    localparam int AD_W   = MEAN_W + 1;
    localparam int PW     = ((2 * AD_W > 96) ? 2 * AD_W : 96) + 1;
    localparam int MC_W   = 6;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DIV1 = 7'b0000010,
        ST_MUL  = 7'b0000100,
        ST_ACC  = 7'b0001000,
        ST_DIV2 = 7'b0010000,
        ST_DIV3 = 7'b0100000,
        ST_SQRT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_pend_reg, out_pend_next;

    logic [COUNT_BITS-1:0]    count_reg, count_next;
    logic signed [MEAN_W-1:0] mean_reg, mean_next;
    logic [63:0]              m2_reg, m2_next;
    logic signed [SAMPLE_BITS-1:0] low_reg, low_next, high_reg, high_next;
    logic                     sat_reg, sat_next;

    logic [AD_W-1:0] ad_reg, ad_next;
    logic            neg_reg, neg_next;
    logic [PW-1:0]   acc_reg, acc_next, mcand_reg, mcand_next;
    logic [AD_W-1:0] mplier_reg, mplier_next;
    logic [MC_W-1:0] mcnt_reg, mcnt_next;
    logic [63:0]     var_reg, var_next, v_reg, v_next;
    logic [33:0]     srem_reg, srem_next;
    logic [31:0]     root_reg, root_next;
    logic            start_reg, start_next;

    logic            m_valid_reg;
    logic [31:0]     o_count_reg, o_mean_reg, o_min_reg, o_max_reg, o_se_reg;
    logic [63:0]     o_m2_reg, o_var_reg;
    logic            o_vv_reg, o_ovf_reg;

    logic [63:0]           div_num;
    logic [COUNT_BITS-1:0] div_den;
    rmvmm_pkg::div_res_t   div_res;

    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [MEAN_W-1:0]      target;
    logic signed [AD_W-1:0]        delta;
    logic [AD_W-1:0]               q_clamp;
    logic [63:0]                   prod;
    logic                          prod_sat;
    logic [64:0]                   m2_sum;
    logic [33:0]                   s_trial, s_shift;
    logic signed [MEAN_W-1:0]      mean_rnd;
    logic                          load_out;
    logic [63:0]                   count_wide;

    rmvmm_div #(.DEN_W(COUNT_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .num     (div_num),
        .den     (div_den),
        .res     (div_res)
    );

    always_comb begin
        div_num = 64'(ad_reg);
        div_den = count_reg;
        if (state_reg == ST_DIV2) begin
            div_num = m2_reg;
            div_den = count_reg - 1'b1;
        end else if (state_reg == ST_DIV3) begin
            div_num = var_reg;
        end
    end

    assign load_out = out_pend_reg && (!m_valid_reg || m_ready);
    assign s_ready  = (state_reg == ST_IDLE) && !out_pend_reg;

    always_comb begin
        x        = s_sample[SAMPLE_BITS-1:0];
        target   = {x, {G{1'b0}}};
        delta    = AD_W'(target) - AD_W'(mean_reg);
        q_clamp  = (div_res.quot > 64'(ad_reg)) ? ad_reg : AD_W'(div_res.quot);
        prod_sat = |acc_reg[PW-1:96];
        prod     = acc_reg[95:32];
        m2_sum   = {1'b0, m2_reg} + {1'b0, prod};
        s_shift  = {srem_reg[31:0], v_reg[63:62]};
        s_trial  = {root_reg, 2'b01};

        state_next    = state_reg;
        out_pend_next = out_pend_reg;
        count_next    = count_reg;
        mean_next     = mean_reg;
        m2_next       = m2_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        sat_next      = sat_reg;
        ad_next       = ad_reg;
        neg_next      = neg_reg;
        acc_next      = acc_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        mcnt_next     = mcnt_reg;
        var_next      = var_reg;
        v_next        = v_reg;
        srem_next     = srem_reg;
        root_next     = root_reg;
        start_next    = 1'b0;

        if (load_out) begin
            out_pend_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    var_next  = '0;
                    root_next = '0;
                    if (count_reg == '0) begin
                        count_next    = COUNT_BITS'(1);
                        mean_next     = target;
                        m2_next       = '0;
                        low_next      = x;
                        high_next     = x;
                        out_pend_next = 1'b1;
                    end else begin
                        if (&count_reg) begin
                            sat_next = 1'b1;
                        end else begin
                            count_next = count_reg + 1'b1;
                        end
                        neg_next   = delta[AD_W-1];
                        ad_next    = delta[AD_W-1] ? AD_W'(-delta) : AD_W'(delta);
                        if (x < low_reg) begin
                            low_next = x;
                        end
                        if (x > high_reg) begin
                            high_next = x;
                        end
                        start_next = 1'b1;
                        state_next = ST_DIV1;
                    end
                end
            end
            ST_DIV1: begin
                if (div_res.done) begin
                    mean_next   = neg_reg ? mean_reg - MEAN_W'(q_clamp)
                                          : mean_reg + MEAN_W'(q_clamp);
                    mplier_next = ad_reg - q_clamp;
                    mcand_next  = PW'(ad_reg);
                    // rounding bias for the drop of 32 fraction bits
                    acc_next    = PW'(64'h8000_0000);
                    mcnt_next   = '0;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                if (mplier_reg[0]) begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[PW-2:0], 1'b0};
                mplier_next = mplier_reg >> 1;
                mcnt_next   = mcnt_reg + 1'b1;
                if (mcnt_reg == MC_W'(AD_W - 1)) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                if (prod_sat || m2_sum[64]) begin
                    m2_next  = '1;
                    sat_next = 1'b1;
                end else begin
                    m2_next = m2_sum[63:0];
                end
                start_next = 1'b1;
                state_next = ST_DIV2;
            end
            ST_DIV2: begin
                if (div_res.done) begin
                    var_next   = div_res.quot;
                    start_next = 1'b1;
                    state_next = ST_DIV3;
                end
            end
            ST_DIV3: begin
                if (div_res.done) begin
                    v_next     = div_res.quot;
                    srem_next  = '0;
                    root_next  = '0;
                    mcnt_next  = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                // two radicand bits per step, one root bit out
                v_next = {v_reg[61:0], 2'b00};
                if (s_shift >= s_trial) begin
                    srem_next = s_shift - s_trial;
                    root_next = {root_reg[30:0], 1'b1};
                end else begin
                    srem_next = s_shift;
                    root_next = {root_reg[30:0], 1'b0};
                end
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == MC_W'(31)) begin
                    out_pend_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign mean_rnd   = mean_reg + MEAN_W'(1 << (G - 1));
    assign count_wide = 64'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            out_pend_reg <= 1'b0;
            start_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
            count_reg    <= '0;
            mean_reg     <= '0;
            m2_reg       <= '0;
            low_reg      <= '0;
            high_reg     <= '0;
            sat_reg      <= 1'b0;
            mcnt_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            out_pend_reg <= out_pend_next;
            start_reg    <= start_next;
            count_reg    <= count_next;
            mean_reg     <= mean_next;
            m2_reg       <= m2_next;
            low_reg      <= low_next;
            high_reg     <= high_next;
            sat_reg      <= sat_next;
            mcnt_reg     <= mcnt_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        ad_reg     <= ad_next;
        neg_reg    <= neg_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        var_reg    <= var_next;
        v_reg      <= v_next;
        srem_reg   <= srem_next;
        root_reg   <= root_next;
        if (load_out) begin
            o_count_reg <= (|count_wide[63:32]) ? 32'hFFFF_FFFF : count_wide[31:0];
            o_mean_reg  <= 32'($signed(mean_rnd[MEAN_W-1:G]));
            o_m2_reg    <= m2_reg;
            o_min_reg   <= 32'(low_reg);
            o_max_reg   <= 32'(high_reg);
            o_var_reg   <= var_reg;
            o_se_reg    <= root_reg;
            o_vv_reg    <= |count_reg[COUNT_BITS-1:1];
            o_ovf_reg   <= sat_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_count          = o_count_reg;
    assign m_mean_out       = o_mean_reg;
    assign m_sq_dev_sum     = o_m2_reg;
    assign m_minimum        = o_min_reg;
    assign m_maximum        = o_max_reg;
    assign m_variance       = o_var_reg;
    assign m_std_error      = o_se_reg;
    assign m_variance_valid = o_vv_reg;
    assign m_overflow       = o_ovf_reg;

endmodule

/* rtl/core/rmvmm_div.sv */
// restoring divider, one quotient bit per cycle, rounded to nearest with ties up
// depends on rmvmm_pkg
`timescale 1ns / 1ps

module rmvmm_div #(
    parameter int DEN_W = rmvmm_pkg::COUNT_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [rmvmm_pkg::DIV_W-1:0]   num,
    input  logic [DEN_W-1:0]              den,
    output rmvmm_pkg::div_res_t           res
);

    localparam int W = rmvmm_pkg::DIV_W;

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [rmvmm_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [W-1:0]     res_reg, res_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   twice_rem;
    logic             fits;

    always_comb begin
        trial     = {rem_reg, quo_reg[W-1]};
        fits      = trial >= {1'b0, den_reg};
        twice_rem = {rem_reg, 1'b0};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        res_next  = res_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
            quo_next = {quo_reg[W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == rmvmm_pkg::DIV_CNT_W'(W)) begin
                // all bits shifted in: round on the remainder
                rem_next  = rem_reg;
                quo_next  = quo_reg;
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = (twice_rem >= {1'b0, den_reg}) ? quo_reg + 1'b1 : quo_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        res_reg <= res_next;
    end

    assign res.done = done_reg;
    assign res.quot = res_reg;

endmodule
